// ===== hw/rtl/amm_pkg.sv =====
// Shared types, constants and field checks for the multi-slot alarm matcher.
// No dependencies; imported by every module of the block.
package amm_pkg;

  localparam int NUM_ALARMS = 5;
  localparam int SLOT_W     = 4;
  localparam int IDX_W      = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;

  localparam int YEAR_W   = 7;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;

  localparam logic [YEAR_W-1:0]   YEAR_MAX   = 7'd99;
  localparam logic [MONTH_W-1:0]  MONTH_MIN  = 4'd1;
  localparam logic [MONTH_W-1:0]  MONTH_MAX  = 4'd12;
  localparam logic [DAY_W-1:0]    DAY_MIN    = 5'd1;
  localparam logic [DAY_W-1:0]    DAY_MAX    = 5'd31;
  localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
  localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_TOGGLE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SLOT   = 2'd1,
    ST_BAD_TIME   = 2'd2,
    ST_EMPTY_SLOT = 2'd3
  } status_e;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } stamp_t;

  typedef struct packed {
    logic   valid;
    logic   enabled;
    stamp_t stamp;
  } alarm_entry_t;

  typedef struct packed {
    logic          vld;
    req_e          req;
    logic [SLOT_W-1:0] slot;
    stamp_t        stamp;
  } req_t;

  function automatic logic stamp_ok(input stamp_t s);
    return (s.year <= YEAR_MAX) &&
           (s.month >= MONTH_MIN) && (s.month <= MONTH_MAX) &&
           (s.day >= DAY_MIN) && (s.day <= DAY_MAX) &&
           (s.hour <= HOUR_MAX) && (s.minute <= MINUTE_MAX);
  endfunction

endpackage

// ===== hw/rtl/amm_slot_table.sv =====
// Alarm slot storage: applies write, remove and toggle requests and reports status.
// Depends on amm_pkg.
module amm_slot_table import amm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  req_t         req_i,
  output status_e      status_o,
  output alarm_entry_t entries_o [NUM_ALARMS]
);

  alarm_entry_t entry_q [NUM_ALARMS];
  alarm_entry_t entry_d [NUM_ALARMS];

  logic             in_range;
  logic [IDX_W-1:0] idx;
  logic             sel_valid;

  assign in_range  = {1'b0, req_i.slot} < (SLOT_W+1)'(NUM_ALARMS);
  assign idx       = req_i.slot[IDX_W-1:0];
  assign sel_valid = in_range ? entry_q[idx].valid : 1'b0;

  always_comb begin
    status_o = ST_OK;
    if (req_i.req != REQ_TICK) begin
      if (!in_range) begin
        status_o = ST_BAD_SLOT;
      end else if (req_i.req == REQ_WRITE && !stamp_ok(req_i.stamp)) begin
        status_o = ST_BAD_TIME;
      end else if (req_i.req == REQ_TOGGLE && !sel_valid) begin
        status_o = ST_EMPTY_SLOT;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_ALARMS; i++) begin
      entry_d[i] = entry_q[i];
    end
    if (req_i.vld && in_range && status_o == ST_OK) begin
      case (req_i.req)
        REQ_WRITE: begin
          entry_d[idx].valid   = 1'b1;
          entry_d[idx].enabled = 1'b1;
          entry_d[idx].stamp   = req_i.stamp;
        end
        REQ_REMOVE: entry_d[idx] = '0;
        REQ_TOGGLE: entry_d[idx].enabled = ~entry_q[idx].enabled;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ALARMS; i++) begin
        entry_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_ALARMS; i++) begin
        entry_q[i] <= entry_d[i];
      end
    end
  end

  assign entries_o = entry_q;

endmodule

// ===== hw/rtl/amm_matcher.sv =====
// Compares every slot with the current time and picks the lowest matching one.
// Depends on amm_pkg.
module amm_matcher import amm_pkg::*; (
  input  alarm_entry_t      entries_i [NUM_ALARMS],
  input  stamp_t            stamp_i,
  output logic              hit_o,
  output logic [SLOT_W-1:0] hit_slot_o
);

  logic [NUM_ALARMS-1:0] match;

  always_comb begin
    for (int i = 0; i < NUM_ALARMS; i++) begin
      match[i] = entries_i[i].valid && entries_i[i].enabled &&
                 (entries_i[i].stamp == stamp_i);
    end
  end

  // scan downwards so the lowest match wins
  always_comb begin
    hit_slot_o = '0;
    for (int i = NUM_ALARMS-1; i >= 0; i--) begin
      if (match[i]) begin
        hit_slot_o = SLOT_W'(i);
      end
    end
  end

  assign hit_o = |match;

endmodule

// ===== hw/rtl/multi_slot_alarm_matcher.sv =====
// Multi-slot alarm matcher, top level.
// Timing: a request passes the input register, then the slot table and matcher, and the
// result register; done_o is registered at the same edge as the result register.
// Throughput: one request per cycle; busy is never raised and done_o cannot be stalled.
// Reset (rst_ni, asynchronous, active low) clears every slot and the active mark.
// Depends on amm_pkg, amm_slot_table and amm_matcher.
module multi_slot_alarm_matcher import amm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          req_type_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic [YEAR_W-1:0]   year_i,
  input  logic [MONTH_W-1:0]  month_i,
  input  logic [DAY_W-1:0]    day_i,
  input  logic [HOUR_W-1:0]   hour_i,
  input  logic [MINUTE_W-1:0] minute_i,
  output logic                done_o,
  output logic [1:0]          status_o,
  output logic                fired_o,
  output logic                active_o,
  output logic [SLOT_W-1:0]   active_slot_o
);

  req_t req_q;
  logic req_vld_q;

  alarm_entry_t      entries [NUM_ALARMS];
  status_e           status;
  logic              hit;
  logic [SLOT_W-1:0] hit_slot;

  logic              last_active_q, last_active_d;
  logic [SLOT_W-1:0] last_slot_q, last_slot_d;
  logic              fired;

  logic              done_q;
  logic [1:0]        status_q;
  logic              fired_q;
  logic              active_q;
  logic [SLOT_W-1:0] active_slot_q;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      req_q.req   <= req_e'(req_type_i);
      req_q.slot  <= slot_i;
      req_q.stamp <= '{year: year_i, month: month_i, day: day_i,
                       hour: hour_i, minute: minute_i};
    end
  end

  req_t req_cur;
  always_comb begin
    req_cur.vld   = req_vld_q;
    req_cur.req   = req_q.req;
    req_cur.slot  = req_q.slot;
    req_cur.stamp = req_q.stamp;
  end

  amm_slot_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_cur),
    .status_o  (status),
    .entries_o (entries)
  );

  amm_matcher u_matcher (
    .entries_i  (entries),
    .stamp_i    (req_q.stamp),
    .hit_o      (hit),
    .hit_slot_o (hit_slot)
  );

  always_comb begin
    last_active_d = last_active_q;
    last_slot_d   = last_slot_q;
    fired         = 1'b0;
    if (req_vld_q && req_q.req == REQ_TICK) begin
      if (hit) begin
        if (!last_active_q || last_slot_q != hit_slot) begin
          fired         = 1'b1;
          last_active_d = 1'b1;
          last_slot_d   = hit_slot;
        end
      end else begin
        // no match: drop the active mark
        last_active_d = 1'b0;
        last_slot_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_active_q <= 1'b0;
      last_slot_q   <= '0;
      done_q        <= 1'b0;
    end else begin
      last_active_q <= last_active_d;
      last_slot_q   <= last_slot_d;
      done_q        <= req_vld_q;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      status_q      <= status;
      fired_q       <= fired;
      active_q      <= last_active_d;
      active_slot_q <= last_active_d ? last_slot_d : '0;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign fired_o       = fired_q;
  assign active_o      = active_q;
  assign active_slot_o = active_slot_q;

endmodule
